// ===== hdl/btcw_pkg.sv =====
// Shared constants, types and helpers of the bordered text console writer.
`default_nettype none
package btcw_pkg;

    localparam int MAX_COLS = 128;
    localparam int MAX_ROWS = 64;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int GC_W     = $clog2(MAX_COLS + 1);
    localparam int GR_W     = $clog2(MAX_ROWS + 1);
    localparam int ADDR_W   = $clog2(MAX_COLS * MAX_ROWS);

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_BAR     = 8'h7C;
    localparam logic [7:0] CH_BLANK   = 8'h20;
    localparam logic [7:0] CH_DASH    = 8'h2D;

    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;
    localparam logic [1:0] REQ_NOP   = 2'd3;

    localparam logic [1:0] CFG_COLS   = 2'd0;
    localparam logic [1:0] CFG_ROWS   = 2'd1;
    localparam logic [1:0] CFG_TEXT   = 2'd2;
    localparam logic [1:0] CFG_BORDER = 2'd3;

    typedef enum logic [2:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_READ,
        OP_CLEAR,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [7:0]       ch;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } entry_t;

    typedef struct packed {
        logic [7:0] cols;
        logic [6:0] rows;
        logic [7:0] text_color;
        logic [7:0] border_color;
    } cfg_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_START,
        B_NEXT,
        B_ADDR,
        B_WRITE,
        B_SC_RD,
        B_SC_WR,
        B_SC_BLANK,
        B_CLR,
        B_RD_ADDR,
        B_RD_MEM,
        B_DONE
    } bstate_t;

    typedef enum logic [2:0] {
        ST_BLANK_R,
        ST_BAR_R,
        ST_CHK0,
        ST_BAR_L,
        ST_BLANK_L,
        ST_CHAR,
        ST_FIN
    } step_t;

    // Clamp the column count into its usable range.
    function automatic logic [GC_W-1:0] eff_cols(input logic [7:0] c);
        logic [GC_W-1:0] r;
        if (c < 8'd5)
            r = GC_W'(5);
        else if ({1'b0, c} > 9'(MAX_COLS))
            r = GC_W'(MAX_COLS);
        else
            r = GC_W'(c);
        return r;
    endfunction

    // Clamp the row count into its usable range.
    function automatic logic [GR_W-1:0] eff_rows(input logic [6:0] h);
        logic [GR_W-1:0] r;
        if (h < 7'd3)
            r = GR_W'(3);
        else if ({1'b0, h} > 8'(MAX_ROWS))
            r = GR_W'(MAX_ROWS);
        else
            r = GR_W'(h);
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/btcw_front.sv =====
// Front end: takes requests and sorts them into operations for the queue.
`default_nettype none
module btcw_front (
    input  wire logic                       start,
    input  wire logic                       full,
    input  wire logic [1:0]                 req_type,
    input  wire logic [7:0]                 char_code,
    input  wire logic [btcw_pkg::ROW_W-1:0] cell_row,
    input  wire logic [btcw_pkg::COL_W-1:0] cell_col,
    output logic                            push,
    output btcw_pkg::entry_t                entry
);

    // Accept when the queue has room.
    assign push = start && !full;

    // Classify the request.
    always_comb
    begin
        entry.ch  = char_code;
        entry.row = cell_row;
        entry.col = cell_col;
        case (req_type)
            btcw_pkg::REQ_PUT:
                entry.op = (char_code == btcw_pkg::CH_NEWLINE) ?
                           btcw_pkg::OP_NEWLINE : btcw_pkg::OP_PUT;
            btcw_pkg::REQ_READ:  entry.op = btcw_pkg::OP_READ;
            btcw_pkg::REQ_CLEAR: entry.op = btcw_pkg::OP_CLEAR;
            default:             entry.op = btcw_pkg::OP_NOP;
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/btcw_queue.sv =====
// Two-entry request queue between front and back end.
`default_nettype none
module btcw_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire btcw_pkg::entry_t din,
    input  wire logic             pop,
    output logic                  empty,
    output logic                  full,
    output btcw_pkg::entry_t      dout
);

    btcw_pkg::entry_t mem_reg [2];
    logic             wp_reg, wp_next;
    logic             rp_reg, rp_next;
    logic [1:0]       cnt_reg, cnt_next;

    assign empty = (cnt_reg == 2'd0);
    assign full  = (cnt_reg == 2'd2);
    assign dout  = mem_reg[rp_reg];

    // Advance pointers and count.
    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Hold the payload.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= din;
    end

endmodule
`default_nettype wire

// ===== hdl/btcw_back.sv =====
// Back end: cell store, cursor and the sequencer that carries out requests.
`default_nettype none
module btcw_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire btcw_pkg::cfg_t             cfg,
    input  wire logic                       empty,
    input  wire btcw_pkg::entry_t           entry,
    output logic                            pop,
    output logic                            done,
    output logic [15:0]                     read_data,
    output logic [btcw_pkg::ROW_W-1:0]      cursor_row_now,
    output logic [btcw_pkg::COL_W-1:0]      cursor_col_now,
    output logic                            scrolled
);

    localparam int AW = btcw_pkg::ADDR_W;
    localparam int CW = btcw_pkg::COL_W;
    localparam int RW = btcw_pkg::ROW_W;
    localparam int GC = btcw_pkg::GC_W;
    localparam int GR = btcw_pkg::GR_W;

    logic [15:0] mem [btcw_pkg::MAX_COLS * btcw_pkg::MAX_ROWS];

    btcw_pkg::bstate_t state_reg, state_next;
    btcw_pkg::step_t   step_reg, step_next;
    btcw_pkg::op_t     op_reg, op_next;
    logic [CW-1:0]     pos_reg, pos_next;
    logic [RW-1:0]     line_reg, line_next;
    logic [7:0]        ch_reg, ch_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [AW:0]       src_reg, src_next;
    logic [GC-1:0]     x_reg, x_next;
    logic [GR-1:0]     y_reg, y_next;
    logic              ok_reg, ok_next;
    logic              scr_reg, scr_next;
    logic [15:0]       rdata_reg;

    logic              done_reg;
    logic [15:0]       rd_out_reg;
    logic [RW-1:0]     crow_reg;
    logic [CW-1:0]     ccol_reg;
    logic              scr_out_reg;

    logic [GC-1:0]     w;
    logic [GR-1:0]     h;
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [15:0]       mem_wd;
    logic [AW-1:0]     rd_addr;
    logic [AW:0]       dst;
    logic [GC:0]       pos_p1;
    logic [GR:0]       line_p1;
    logic [15:0]       step_cell;
    logic [RW+GC-1:0]  prod;

    assign w   = btcw_pkg::eff_cols(cfg.cols);
    assign h   = btcw_pkg::eff_rows(cfg.rows);
    assign dst = src_reg - (AW+1)'(w);
    assign pop = (state_reg == btcw_pkg::B_IDLE) && !empty;

    assign done           = done_reg;
    assign read_data      = rd_out_reg;
    assign cursor_row_now = crow_reg;
    assign cursor_col_now = ccol_reg;
    assign scrolled       = scr_out_reg;

    // Pick the cell for the current put step.
    always_comb
    begin
        case (step_reg)
            btcw_pkg::ST_BLANK_R: step_cell = {cfg.border_color, btcw_pkg::CH_BLANK};
            btcw_pkg::ST_BAR_R:   step_cell = {cfg.border_color, btcw_pkg::CH_BAR};
            btcw_pkg::ST_BAR_L:   step_cell = {cfg.border_color, btcw_pkg::CH_BAR};
            btcw_pkg::ST_BLANK_L: step_cell = {cfg.border_color, btcw_pkg::CH_BLANK};
            default:              step_cell = {cfg.text_color, ch_reg};
        endcase
    end

    // Sequence the requests.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        op_next    = op_reg;
        pos_next   = pos_reg;
        line_next  = line_reg;
        ch_next    = ch_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        addr_next  = addr_reg;
        src_next   = src_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        ok_next    = ok_reg;
        scr_next   = scr_reg;
        mem_we     = 1'b0;
        mem_wa     = addr_reg;
        mem_wd     = step_cell;
        rd_addr    = addr_reg;
        pos_p1     = (GC+1)'(pos_reg) + 1'b1;
        line_p1    = (GR+1)'(line_reg) + 1'b1;
        prod       = '0;

        case (state_reg)
            btcw_pkg::B_IDLE:
            begin
                if (!empty)
                begin
                    op_next    = entry.op;
                    ch_next    = entry.ch;
                    row_next   = entry.row;
                    col_next   = entry.col;
                    scr_next   = 1'b0;
                    state_next = btcw_pkg::B_START;
                end
            end

            btcw_pkg::B_START:
            begin
                case (op_reg)
                    btcw_pkg::OP_PUT:
                    begin
                        step_next  = ((GC+1)'(pos_reg) + 2'd2 == (GC+1)'(w)) ?
                                     btcw_pkg::ST_BLANK_R : btcw_pkg::ST_CHK0;
                        state_next = btcw_pkg::B_NEXT;
                    end
                    btcw_pkg::OP_NEWLINE:
                    begin
                        step_next  = btcw_pkg::ST_FIN;
                        pos_next   = '0;
                        state_next = btcw_pkg::B_NEXT;
                        if (line_p1 + 1'b1 >= (GR+1)'(h))
                        begin
                            line_next  = RW'(h - 2'd2);
                            scr_next   = 1'b1;
                            src_next   = (AW+1)'({w, 1'b0}) + 2'd2;
                            x_next     = GC'(2);
                            y_next     = GR'(2);
                            state_next = (h == GR'(3)) ? btcw_pkg::B_SC_BLANK :
                                                         btcw_pkg::B_SC_RD;
                        end
                        else
                            line_next = RW'(line_p1);
                    end
                    btcw_pkg::OP_READ:  state_next = btcw_pkg::B_RD_ADDR;
                    btcw_pkg::OP_CLEAR:
                    begin
                        x_next     = '0;
                        y_next     = '0;
                        addr_next  = '0;
                        state_next = btcw_pkg::B_CLR;
                    end
                    default:            state_next = btcw_pkg::B_DONE;
                endcase
            end

            btcw_pkg::B_NEXT:
            begin
                state_next = btcw_pkg::B_ADDR;
                case (step_reg)
                    btcw_pkg::ST_CHK0:
                        step_next = (pos_reg == '0) ? btcw_pkg::ST_BAR_L :
                                                      btcw_pkg::ST_CHAR;
                    btcw_pkg::ST_FIN: state_next = btcw_pkg::B_DONE;
                    default:          step_next = step_reg;
                endcase
            end

            btcw_pkg::B_ADDR:
            begin
                prod       = line_reg * w;
                addr_next  = AW'(prod + (RW+GC)'(pos_reg));
                ok_next    = ((GC+1)'(pos_reg) < (GC+1)'(w)) &&
                             ((GR+1)'(line_reg) < (GR+1)'(h));
                state_next = btcw_pkg::B_WRITE;
            end

            btcw_pkg::B_WRITE:
            begin
                mem_we     = ok_reg;
                state_next = btcw_pkg::B_NEXT;
                case (step_reg)
                    btcw_pkg::ST_BLANK_R: step_next = btcw_pkg::ST_BAR_R;
                    btcw_pkg::ST_BAR_R:   step_next = btcw_pkg::ST_CHK0;
                    btcw_pkg::ST_BAR_L:   step_next = btcw_pkg::ST_BLANK_L;
                    btcw_pkg::ST_BLANK_L: step_next = btcw_pkg::ST_CHAR;
                    default:              step_next = btcw_pkg::ST_FIN;
                endcase
                // Advance the cursor, wrapping and scrolling as needed.
                if (pos_p1 >= (GC+1)'(w))
                begin
                    pos_next = '0;
                    if (line_p1 + 1'b1 >= (GR+1)'(h))
                    begin
                        line_next  = RW'(h - 2'd2);
                        scr_next   = 1'b1;
                        src_next   = (AW+1)'({w, 1'b0}) + 2'd2;
                        x_next     = GC'(2);
                        y_next     = GR'(2);
                        state_next = (h == GR'(3)) ? btcw_pkg::B_SC_BLANK :
                                                     btcw_pkg::B_SC_RD;
                    end
                    else
                        line_next = RW'(line_p1);
                end
                else
                    pos_next = CW'(pos_p1);
            end

            btcw_pkg::B_SC_RD:
            begin
                rd_addr    = AW'(src_reg);
                state_next = btcw_pkg::B_SC_WR;
            end

            btcw_pkg::B_SC_WR:
            begin
                mem_we     = 1'b1;
                mem_wa     = AW'(dst);
                mem_wd     = rdata_reg;
                state_next = btcw_pkg::B_SC_RD;
                if ((GC+1)'(x_reg) + 2'd3 == (GC+1)'(w))
                begin
                    x_next   = GC'(2);
                    y_next   = y_reg + 1'b1;
                    src_next = src_reg + 3'd5;
                    if ((GR+1)'(y_reg) + 2'd2 == (GR+1)'(h))
                        state_next = btcw_pkg::B_SC_BLANK;
                end
                else
                begin
                    x_next   = x_reg + 1'b1;
                    src_next = src_reg + 1'b1;
                end
            end

            btcw_pkg::B_SC_BLANK:
            begin
                mem_we   = 1'b1;
                mem_wa   = AW'(dst);
                mem_wd   = {cfg.text_color, btcw_pkg::CH_BLANK};
                x_next   = x_reg + 1'b1;
                src_next = src_reg + 1'b1;
                if ((GC+1)'(x_reg) + 2'd3 == (GC+1)'(w))
                    state_next = btcw_pkg::B_NEXT;
            end

            btcw_pkg::B_CLR:
            begin
                mem_we = 1'b1;
                if (y_reg == '0 || (GR+1)'(y_reg) + 1'b1 == (GR+1)'(h))
                    mem_wd = {cfg.border_color, btcw_pkg::CH_DASH};
                else if (x_reg == '0 || (GC+1)'(x_reg) + 1'b1 == (GC+1)'(w))
                    mem_wd = {cfg.border_color, btcw_pkg::CH_BAR};
                else if (x_reg == GC'(1) || (GC+1)'(x_reg) + 2'd2 == (GC+1)'(w))
                    mem_wd = {cfg.border_color, btcw_pkg::CH_BLANK};
                else
                    mem_wd = {cfg.text_color, btcw_pkg::CH_BLANK};
                addr_next = addr_reg + 1'b1;
                if ((GC+1)'(x_reg) + 1'b1 == (GC+1)'(w))
                begin
                    x_next = '0;
                    y_next = y_reg + 1'b1;
                    if ((GR+1)'(y_reg) + 1'b1 == (GR+1)'(h))
                        state_next = btcw_pkg::B_DONE;
                end
                else
                    x_next = x_reg + 1'b1;
            end

            btcw_pkg::B_RD_ADDR:
            begin
                prod       = row_reg * w;
                addr_next  = AW'(prod + (RW+GC)'(col_reg));
                ok_next    = ((GR+1)'(row_reg) < (GR+1)'(h)) &&
                             ((GC+1)'(col_reg) < (GC+1)'(w));
                state_next = btcw_pkg::B_RD_MEM;
            end

            btcw_pkg::B_RD_MEM: state_next = btcw_pkg::B_DONE;

            btcw_pkg::B_DONE:   state_next = btcw_pkg::B_IDLE;

            default:            state_next = btcw_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= btcw_pkg::B_IDLE;
            step_reg    <= btcw_pkg::ST_FIN;
            pos_reg     <= '0;
            line_reg    <= RW'(1);
            scr_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            pos_reg   <= pos_next;
            line_reg  <= line_next;
            scr_reg   <= scr_next;
            done_reg  <= (state_reg == btcw_pkg::B_DONE);
        end
    end

    // Hold working payload and the result fields.
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        ch_reg   <= ch_next;
        row_reg  <= row_next;
        col_reg  <= col_next;
        addr_reg <= addr_next;
        src_reg  <= src_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        ok_reg   <= ok_next;
        if (state_reg == btcw_pkg::B_DONE)
        begin
            rd_out_reg  <= (op_reg == btcw_pkg::OP_READ && ok_reg) ? rdata_reg : 16'd0;
            crow_reg    <= line_reg;
            ccol_reg    <= pos_reg;
            scr_out_reg <= scr_reg;
        end
    end

    // Cell store: one write and one registered read a cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rdata_reg <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== hdl/bordered_text_console_writer.sv =====
// Top level of the bordered text console writer.
//
//  channel  | signals                                         | handshake
//  ---------+-------------------------------------------------+---------------------
//  request  | req_type, char_code, cell_row, cell_col         | start && !busy
//  result   | read_data, cursor_row_now, cursor_col_now,      | done, one cycle
//           | scrolled                                        |
//  config   | cfg_we, cfg_index, cfg_data                     | cfg_we
//
// A two-entry queue sits between the front end and the sequencer; busy is
// high while it is full. The sequencer takes a request from the queue
// whenever it is idle and strobes done the cycle after it finishes.
// A put writes its character, after a blank and bar pair at the right
// edge and a bar and blank pair at column 0 where needed. A newline moves
// the cursor, a read fetches one cell, a clear redraws the whole frame and a
// scroll copies the text area up one row and blanks its bottom text row.
// Reset puts the cursor on row 1, column 0; the cell store is not cleared.
`default_nettype none
module bordered_text_console_writer (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [1:0]                 req_type,
    input  wire logic [7:0]                 char_code,
    input  wire logic [btcw_pkg::ROW_W-1:0] cell_row,
    input  wire logic [btcw_pkg::COL_W-1:0] cell_col,
    output logic                            done,
    output logic [15:0]                     read_data,
    output logic [btcw_pkg::ROW_W-1:0]      cursor_row_now,
    output logic [btcw_pkg::COL_W-1:0]      cursor_col_now,
    output logic                            scrolled,
    input  wire logic                       cfg_we,
    input  wire logic [1:0]                 cfg_index,
    input  wire logic [7:0]                 cfg_data
);

    btcw_pkg::cfg_t   cfg_reg;
    btcw_pkg::entry_t f_entry;
    btcw_pkg::entry_t q_entry;
    logic             push;
    logic             pop;
    logic             empty;
    logic             full;

    assign busy = full;

    // Write configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cols         <= 8'd80;
            cfg_reg.rows         <= 7'd25;
            cfg_reg.text_color   <= 8'd2;
            cfg_reg.border_color <= 8'd2;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                btcw_pkg::CFG_COLS:   cfg_reg.cols         <= cfg_data;
                btcw_pkg::CFG_ROWS:   cfg_reg.rows         <= cfg_data[6:0];
                btcw_pkg::CFG_TEXT:   cfg_reg.text_color   <= cfg_data;
                btcw_pkg::CFG_BORDER: cfg_reg.border_color <= cfg_data;
                default:              cfg_reg              <= cfg_reg;
            endcase
        end
    end

    btcw_front u_front (
        .start     (start),
        .full      (full),
        .req_type  (req_type),
        .char_code (char_code),
        .cell_row  (cell_row),
        .cell_col  (cell_col),
        .push      (push),
        .entry     (f_entry)
    );

    btcw_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (f_entry),
        .pop   (pop),
        .empty (empty),
        .full  (full),
        .dout  (q_entry)
    );

    btcw_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .empty          (empty),
        .entry          (q_entry),
        .pop            (pop),
        .done           (done),
        .read_data      (read_data),
        .cursor_row_now (cursor_row_now),
        .cursor_col_now (cursor_col_now),
        .scrolled       (scrolled)
    );

endmodule
`default_nettype wire

// ===== tb/sv/btcw_checker.sv =====
// Checker of the bordered text console writer: predicts cells and cursor, compares results.
`default_nettype none
module btcw_checker
    import btcw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire logic [1:0]        req_type,
    input  wire logic [7:0]        char_code,
    input  wire logic [ROW_W-1:0]  cell_row,
    input  wire logic [COL_W-1:0]  cell_col,
    input  wire logic              done,
    input  wire logic [15:0]       read_data,
    input  wire logic [ROW_W-1:0]  cursor_row_now,
    input  wire logic [COL_W-1:0]  cursor_col_now,
    input  wire logic              scrolled,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [7:0]        cfg_data,
    output int                     fail_count,
    output int                     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0]      data;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             scr;
    } console_result_t;

    logic [15:0]     cells [MAX_COLS*MAX_ROWS];
    cfg_t            geom;
    int              line_now;
    int              pos_now;
    logic            scroll_hit;
    console_result_t pending_results [$];

    assign outstanding = pending_results.size();

    function automatic int width_now();
        int c;
        c = geom.cols;
        if (c < 5) c = 5;
        if (c > MAX_COLS) c = MAX_COLS;
        return c;
    endfunction

    function automatic int height_now();
        int r;
        r = geom.rows;
        if (r < 3) r = 3;
        if (r > MAX_ROWS) r = MAX_ROWS;
        return r;
    endfunction

    // Write one cell; drop it when it falls outside the screen.
    function automatic void poke(logic [7:0] ch, logic [7:0] attr, int x, int y);
        int w;
        w = width_now();
        if (x < w && y < height_now())
            cells[y*w+x] = {attr, ch};
    endfunction

    // Move the text area up one row and blank the bottom text row.
    function automatic void shift_text_up();
        int w;
        int h;
        w = width_now();
        h = height_now();
        for (int y = 2; y < h - 1; y++)
            for (int x = 2; x < w - 2; x++)
                cells[(y-1)*w+x] = cells[y*w+x];
        for (int x = 2; x < w - 2; x++)
            poke(CH_BLANK, geom.text_color, x, h - 2);
        scroll_hit = 1'b1;
    endfunction

    function automatic void line_feed();
        pos_now = 0;
        line_now++;
        if (line_now >= height_now() - 1) begin
            line_now = height_now() - 2;
            shift_text_up();
        end
    endfunction

    function automatic void step_right();
        pos_now++;
        if (pos_now >= width_now())
            line_feed();
    endfunction

    // Place a character, adding the right or left bar pair where needed.
    function automatic void type_char(logic [7:0] ch);
        if (ch == CH_NEWLINE) begin
            line_feed();
            return;
        end
        if (pos_now == width_now() - 2) begin
            poke(CH_BLANK, geom.border_color, pos_now, line_now);
            step_right();
            poke(CH_BAR, geom.border_color, pos_now, line_now);
            step_right();
        end
        if (pos_now == 0) begin
            poke(CH_BAR, geom.border_color, pos_now, line_now);
            step_right();
            poke(CH_BLANK, geom.border_color, pos_now, line_now);
            step_right();
        end
        poke(ch, geom.text_color, pos_now, line_now);
        step_right();
    endfunction

    function automatic void paint_frame();
        int w;
        int h;
        w = width_now();
        h = height_now();
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++) begin
                if (y == 0 || y == h - 1)
                    poke(CH_DASH, geom.border_color, x, y);
                else if (x == 0 || x == w - 1)
                    poke(CH_BAR, geom.border_color, x, y);
                else if (x == 1 || x == w - 2)
                    poke(CH_BLANK, geom.border_color, x, y);
                else
                    poke(CH_BLANK, geom.text_color, x, y);
            end
    endfunction

    function automatic console_result_t apply_request(logic [1:0] kind, logic [7:0] ch,
                                                      int row, int col);
        console_result_t r;
        r.data = '0;
        scroll_hit = 1'b0;
        case (kind)
            REQ_PUT: type_char(ch);
            REQ_READ:
                if (row < height_now() && col < width_now())
                    r.data = cells[row*width_now()+col];
            REQ_CLEAR: paint_frame();
            default: ;
        endcase
        r.row = ROW_W'(line_now);
        r.col = COL_W'(pos_now);
        r.scr = scroll_hit;
        return r;
    endfunction

    // Track registers, predict accepted requests and check each strobed result.
    always @(posedge clk or negedge rst_n) begin
        console_result_t want;
        if (!rst_n) begin
            geom.cols         <= 8'd80;
            geom.rows         <= 7'd25;
            geom.text_color   <= 8'd2;
            geom.border_color <= 8'd2;
            line_now          = 1;
            pos_now           = 0;
            fail_count        <= 0;
            pending_results.delete();
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_COLS:   geom.cols         <= cfg_data;
                    CFG_ROWS:   geom.rows         <= cfg_data[6:0];
                    CFG_TEXT:   geom.text_color   <= cfg_data;
                    CFG_BORDER: geom.border_color <= cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
                pending_results.push_back(apply_request(req_type, char_code,
                                                        cell_row, cell_col));
            if (done) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result data=%h row=%0d col=%0d scrolled=%0d",
                             $time, read_data, cursor_row_now, cursor_col_now, scrolled);
                    fail_count <= fail_count + 1;
                end
                else begin
                    want = pending_results.pop_front();
                    if (want.data !== read_data || want.row !== cursor_row_now
                        || want.col !== cursor_col_now || want.scr !== scrolled) begin
                        $display("%0t: mismatch expected data=%h row=%0d col=%0d scrolled=%0d",
                                 $time, want.data, want.row, want.col, want.scr);
                        $display("%0t:          actual   data=%h row=%0d col=%0d scrolled=%0d",
                                 $time, read_data, cursor_row_now, cursor_col_now, scrolled);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== tb/sv/tb_bordered_text_console_writer.sv =====
// Testbench top of the bordered text console writer: stimulus, register phases and verdict.
`default_nettype none
module tb_bordered_text_console_writer;
    import btcw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [1:0]       req_type;
    logic [7:0]       char_code;
    logic [ROW_W-1:0] cell_row;
    logic [COL_W-1:0] cell_col;
    logic             done;
    logic [15:0]      read_data;
    logic [ROW_W-1:0] cursor_row_now;
    logic [COL_W-1:0] cursor_col_now;
    logic             scrolled;
    logic             cfg_we;
    logic [1:0]       cfg_index;
    logic [7:0]       cfg_data;
    int               fail_count;
    int               outstanding;
    int               cycles;
    logic             frame_drawn;
    int               gap_pct;

    bordered_text_console_writer i_dut (.*);

    btcw_checker i_checker (.*);

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stop a hung run.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Drive one request and hold it until accepted.
    task automatic send_request(logic [1:0] kind, logic [7:0] ch, int row, int col);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            @(negedge clk);
            start = 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge clk);
        end
        else
            @(negedge clk);
        req_type  = kind;
        char_code = ch;
        cell_row  = ROW_W'(row);
        cell_col  = COL_W'(col);
        start     = 1'b1;
        if (kind == REQ_CLEAR)
            frame_drawn = 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // Drop start and wait until every request has answered.
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_COLS || idx == CFG_ROWS)
            frame_drawn = 1'b0;
    endtask

    task automatic setup(logic [7:0] c, logic [7:0] r, logic [7:0] tc, logic [7:0] bc);
        drain();
        write_reg(CFG_COLS, c);
        write_reg(CFG_ROWS, r);
        write_reg(CFG_TEXT, tc);
        write_reg(CFG_BORDER, bc);
    endtask

    // Random mix of puts, newlines, reads, clears and unknown requests.
    task automatic random_requests(int count, int nl_pct, int clear_pct);
        int pick;
        logic [1:0] kind;
        logic [7:0] ch;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            ch   = 8'($urandom);
            if (n == 3 && !frame_drawn)
                kind = REQ_CLEAR;
            else if (pick < 3)
                kind = REQ_NOP;
            else if (pick < 3 + clear_pct)
                kind = REQ_CLEAR;
            else if (pick < 20 + clear_pct && frame_drawn)
                kind = REQ_READ;
            else begin
                kind = REQ_PUT;
                if (pick >= 100 - nl_pct)
                    ch = CH_NEWLINE;
            end
            send_request(kind, ch, $urandom_range(0, 63), $urandom_range(0, 127));
        end
    endtask

    initial begin
        cycles      = 0;
        start       = 1'b0;
        req_type    = REQ_PUT;
        char_code   = '0;
        cell_row    = '0;
        cell_col    = '0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_COLS;
        cfg_data    = '0;
        frame_drawn = 1'b0;
        gap_pct     = 0;
        rst_n       = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset geometry, frame corners, character extremes, odd requests.
        send_request(REQ_PUT, 8'h41, 0, 0);
        send_request(REQ_NOP, 8'hFF, 63, 127);
        send_request(REQ_CLEAR, 8'h00, 0, 0);
        send_request(REQ_READ, 8'h00, 0, 0);
        send_request(REQ_READ, 8'h00, 24, 79);
        send_request(REQ_READ, 8'h00, 1, 1);
        send_request(REQ_READ, 8'h00, 25, 0);
        send_request(REQ_READ, 8'h00, 0, 80);
        send_request(REQ_READ, 8'h00, 63, 127);
        send_request(REQ_PUT, 8'h00, 0, 0);
        send_request(REQ_PUT, 8'hFF, 0, 0);
        send_request(REQ_PUT, CH_NEWLINE, 0, 0);
        send_request(REQ_READ, 8'h00, 1, 2);
        setup(8'd5, 8'd3, 8'h00, 8'hFF);
        send_request(REQ_CLEAR, 8'h00, 0, 0);
        for (int k = 0; k < 6; k++)
            send_request(REQ_PUT, 8'h30 + 8'(k), 0, 0);
        send_request(REQ_READ, 8'h00, 1, 2);
        send_request(REQ_PUT, CH_NEWLINE, 0, 0);

        // Random phases over several geometries and colors.
        random_requests(50, 15, 3);
        setup(8'd12, 8'd6, 8'hFF, 8'h00);
        gap_pct = 58;
        random_requests(110, 12, 3);
        setup(8'd0, 8'd0, 8'($urandom), 8'($urandom));
        gap_pct = 6;
        random_requests(40, 15, 3);
        setup(8'd20, 8'd8, 8'($urandom), 8'($urandom));
        gap_pct = 0;
        random_requests(110, 10, 2);
        setup(8'd128, 8'd64, 8'($urandom), 8'($urandom));
        gap_pct = 58;
        random_requests(30, 60, 0);
        setup(8'd255, 8'd127, 8'($urandom), 8'($urandom));
        gap_pct = 6;
        random_requests(12, 10, 0);
        setup(8'd9, 8'd4, 8'($urandom), 8'($urandom));
        gap_pct = 58;
        random_requests(80, 12, 4);

        drain();
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire
